/* sv/miv_pkg.sv */
// Shared widths, types and latency figures for the 3x3 matrix inverse unit.
package miv_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned ELEM_W    = 32;
  localparam int unsigned NUM_ELEMS = 9;
  // Adjugate entries are differences of 32x32 products.
  localparam int unsigned ADJ_W     = 2 * ELEM_W + 1;
  // Determinant is a sum of three 32 x 65 bit products.
  localparam int unsigned DET_W     = ELEM_W + ADJ_W + 2;
  localparam int unsigned DMAG_W    = DET_W - 1;
  localparam int unsigned NUM_W     = ADJ_W + 2 * FRAC_BITS;
  // Quotient bits kept by each divider lane; anything larger saturates.
  localparam int unsigned QB        = ELEM_W + 1;
  localparam int unsigned DIV_W     = DMAG_W + QB;
  localparam int unsigned DFLD_W    = DMAG_W - 2 * FRAC_BITS;
  localparam int unsigned FRONT_LAT = 5;
  localparam int unsigned LANE_LAT  = QB + 1;
  localparam int unsigned LATENCY   = FRONT_LAT + LANE_LAT + 1;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic [NUM_ELEMS-1:0][ELEM_W-1:0] mat_t;

  typedef struct packed {
    logic [NUM_W-1:0]  num;
    logic [DMAG_W-1:0] dmag;
    logic              neg;
  } lane_in_t;

  typedef struct packed {
    logic [QB-1:0] q;
    logic          ovf;
    logic          neg;
  } lane_out_t;

endpackage

/* sv/miv_front.sv */
// Adjugate, determinant and divider operand preparation pipeline.
module miv_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_vld,
  input  miv_pkg::mat_t                         in_a,
  output logic                                  out_vld,
  output miv_pkg::lane_in_t [miv_pkg::NUM_ELEMS-1:0] out_lanes,
  output logic [miv_pkg::ELEM_W-1:0]            out_det,
  output logic                                  out_singular
);
  import miv_pkg::*;

  function automatic logic signed [ADJ_W-1:0] cof(input logic [ELEM_W-1:0] x,
                                                  input logic [ELEM_W-1:0] y,
                                                  input logic [ELEM_W-1:0] u,
                                                  input logic [ELEM_W-1:0] w);
    logic signed [2*ELEM_W-1:0] p1;
    logic signed [2*ELEM_W-1:0] p2;
    p1 = $signed(x) * $signed(y);
    p2 = $signed(u) * $signed(w);
    return ADJ_W'(p1) - ADJ_W'(p2);
  endfunction

  logic [FRONT_LAT-1:0] vld_r;
  mat_t a_r;
  logic [2:0][ELEM_W-1:0] row_r;
  logic signed [ADJ_W-1:0] adj2_r [NUM_ELEMS];
  logic signed [ADJ_W-1:0] adj3_r [NUM_ELEMS];
  logic signed [ADJ_W-1:0] adj4_r [NUM_ELEMS];
  logic signed [ADJ_W-1:0] plo_r [3];
  logic signed [ADJ_W-1:0] phi_r [3];
  logic signed [DET_W-1:0] det_r;
  logic signed [DET_W-1:0] det_nxt;
  logic signed [ADJ_W-1:0] adj_nxt [NUM_ELEMS];
  logic signed [DET_W-1:0] det_abs;
  logic [DMAG_W-1:0] dmag;
  logic [DFLD_W-1:0] dfld;
  logic dneg;
  logic [ELEM_W-1:0] det_fld_nxt;
  lane_in_t [NUM_ELEMS-1:0] lanes_nxt;
  lane_in_t [NUM_ELEMS-1:0] lanes_r;
  logic [ELEM_W-1:0] det_fld_r;
  logic sing_r;

  always_comb begin
    adj_nxt[0] = cof(a_r[4], a_r[8], a_r[7], a_r[5]);
    adj_nxt[1] = cof(a_r[2], a_r[7], a_r[1], a_r[8]);
    adj_nxt[2] = cof(a_r[1], a_r[5], a_r[2], a_r[4]);
    adj_nxt[3] = cof(a_r[6], a_r[5], a_r[3], a_r[8]);
    adj_nxt[4] = cof(a_r[0], a_r[8], a_r[6], a_r[2]);
    adj_nxt[5] = cof(a_r[3], a_r[2], a_r[0], a_r[5]);
    adj_nxt[6] = cof(a_r[3], a_r[7], a_r[6], a_r[4]);
    adj_nxt[7] = cof(a_r[6], a_r[1], a_r[0], a_r[7]);
    adj_nxt[8] = cof(a_r[0], a_r[4], a_r[3], a_r[1]);
  end

  always_comb begin
    det_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      det_nxt = det_nxt + (DET_W'(phi_r[k]) <<< ELEM_W) + DET_W'(plo_r[k]);
    end
  end

  // Sign and magnitude split ahead of the unsigned divider lanes.
  always_comb begin
    dneg    = det_r[DET_W-1];
    det_abs = dneg ? -det_r : det_r;
    dmag    = det_abs[DMAG_W-1:0];
    dfld    = dmag[DMAG_W-1:2*FRAC_BITS];
    if (dneg) begin
      det_fld_nxt = (dfld > (DFLD_W'(1) << (ELEM_W - 1))) ?
                    {1'b1, {(ELEM_W-1){1'b0}}} : ELEM_W'(-dfld);
    end else begin
      det_fld_nxt = (dfld > DFLD_W'({1'b0, {(ELEM_W-1){1'b1}}})) ?
                    {1'b0, {(ELEM_W-1){1'b1}}} : ELEM_W'(dfld);
    end
    for (int k = 0; k < NUM_ELEMS; k++) begin
      logic signed [ADJ_W-1:0] amag;
      amag = adj4_r[k][ADJ_W-1] ? -adj4_r[k] : adj4_r[k];
      lanes_nxt[k].num  = NUM_W'(amag) << (2 * FRAC_BITS);
      lanes_nxt[k].dmag = dmag;
      lanes_nxt[k].neg  = adj4_r[k][ADJ_W-1] ^ dneg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[FRONT_LAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    a_r <= in_a;
    row_r <= {a_r[2], a_r[1], a_r[0]};
    for (int k = 0; k < NUM_ELEMS; k++) begin
      adj2_r[k] <= adj_nxt[k];
      adj3_r[k] <= adj2_r[k];
      adj4_r[k] <= adj3_r[k];
    end
    for (int k = 0; k < 3; k++) begin
      plo_r[k] <= $signed(row_r[k]) * $signed({1'b0, adj2_r[3*k][ELEM_W-1:0]});
      phi_r[k] <= $signed(row_r[k]) * $signed(adj2_r[3*k][ADJ_W-1:ELEM_W]);
    end
    det_r     <= det_nxt;
    lanes_r   <= lanes_nxt;
    det_fld_r <= det_fld_nxt;
    sing_r    <= (det_r == '0);
  end

  assign out_vld      = vld_r[FRONT_LAT-1];
  assign out_lanes    = lanes_r;
  assign out_det      = det_fld_r;
  assign out_singular = sing_r;

endmodule

/* sv/miv_lane.sv */
// One pipelined restoring divider lane: adjugate magnitude over determinant.
module miv_lane (
  input  logic               clk,
  input  miv_pkg::lane_in_t  lin,
  output miv_pkg::lane_out_t lout
);
  import miv_pkg::*;

  logic [DIV_W-1:0]  rem_r [QB+1];
  logic [DMAG_W-1:0] dm_r  [QB+1];
  logic [QB-1:0]     q_r   [QB+1];
  logic              ovf_r [QB+1];
  logic              neg_r [QB+1];

  // Anything at or above 2^QB saturates, so only QB quotient bits are formed.
  always_ff @(posedge clk) begin
    rem_r[0] <= DIV_W'(lin.num);
    dm_r[0]  <= lin.dmag;
    q_r[0]   <= '0;
    ovf_r[0] <= DIV_W'(lin.num) >= (DIV_W'(lin.dmag) << QB);
    neg_r[0] <= lin.neg;
  end

  for (genvar s = 1; s <= QB; s++) begin : g_stage
    logic [DIV_W-1:0] dsh;
    logic             take;
    assign dsh  = DIV_W'(dm_r[s-1]) << (QB - s);
    assign take = rem_r[s-1] >= dsh;
    always_ff @(posedge clk) begin
      rem_r[s] <= take ? rem_r[s-1] - dsh : rem_r[s-1];
      q_r[s]   <= q_r[s-1] | (take ? (QB'(1) << (QB - s)) : '0);
      dm_r[s]  <= dm_r[s-1];
      ovf_r[s] <= ovf_r[s-1];
      neg_r[s] <= neg_r[s-1];
    end
  end

  assign lout.q   = q_r[QB];
  assign lout.ovf = ovf_r[QB];
  assign lout.neg = neg_r[QB];

endmodule

/* sv/miv_merge.sv */
// Merging stage: applies signs, saturates lane quotients, zeroes singular results and registers the result.
module miv_merge (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_vld,
  input  miv_pkg::lane_out_t [miv_pkg::NUM_ELEMS-1:0] in_lanes,
  input  logic [miv_pkg::ELEM_W-1:0]                  in_det,
  input  logic                                        in_singular,
  output logic                                        out_vld,
  output miv_pkg::mat_t                               out_inv,
  output logic [miv_pkg::ELEM_W-1:0]                  out_det,
  output logic                                        out_singular
);
  import miv_pkg::*;

  logic vld_r;
  logic sing_r;
  mat_t inv_r;
  mat_t inv_nxt;
  logic [ELEM_W-1:0] det_r;

  always_comb begin
    for (int k = 0; k < NUM_ELEMS; k++) begin
      if (in_singular) begin
        inv_nxt[k] = '0;
      end else if (in_lanes[k].neg) begin
        inv_nxt[k] = (in_lanes[k].ovf || in_lanes[k].q > (QB'(1) << (ELEM_W - 1))) ?
                     {1'b1, {(ELEM_W-1){1'b0}}} : ELEM_W'(-in_lanes[k].q);
      end else begin
        inv_nxt[k] = (in_lanes[k].ovf || in_lanes[k].q[QB-1:ELEM_W-1] != '0) ?
                     {1'b0, {(ELEM_W-1){1'b1}}} : in_lanes[k].q[ELEM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      sing_r <= 1'b0;
    end else begin
      vld_r  <= in_vld;
      sing_r <= in_vld & in_singular;
    end
  end

  always_ff @(posedge clk) begin
    inv_r <= inv_nxt;
    det_r <= in_singular ? '0 : in_det;
  end

  assign out_vld      = vld_r;
  assign out_inv      = inv_r;
  assign out_det      = det_r;
  assign out_singular = sing_r;

endmodule

/* sv/matrix_inverse_3x3_unit.sv */
// Top level of the 3x3 fixed-point matrix inverse unit.
//
//   channel   handshake          payload
//   input     start / busy       in_a00 .. in_a22
//   result    out_valid strobe   out_inv00 .. out_inv22, out_determinant, out_singular
//
// One matrix may start every cycle while busy is low.
// The nine parallel divider lanes form one quotient bit per stage.
// busy is high only during reset and on the first cycle after it.
// Synchronous active-low reset clears all valid bits; results in flight are dropped.
// Results are shown for one cycle and cannot be held off.
module matrix_inverse_3x3_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_a00,
  input  logic [31:0] in_a01,
  input  logic [31:0] in_a02,
  input  logic [31:0] in_a10,
  input  logic [31:0] in_a11,
  input  logic [31:0] in_a12,
  input  logic [31:0] in_a20,
  input  logic [31:0] in_a21,
  input  logic [31:0] in_a22,
  output logic        out_valid,
  output logic [31:0] out_inv00,
  output logic [31:0] out_inv01,
  output logic [31:0] out_inv02,
  output logic [31:0] out_inv10,
  output logic [31:0] out_inv11,
  output logic [31:0] out_inv12,
  output logic [31:0] out_inv20,
  output logic [31:0] out_inv21,
  output logic [31:0] out_inv22,
  output logic [31:0] out_determinant,
  output logic        out_singular
);
  import miv_pkg::*;

  logic busy_r;
  logic accept;
  mat_t mat;
  logic f_vld;
  lane_in_t [NUM_ELEMS-1:0] f_lanes;
  logic [ELEM_W-1:0] f_det;
  logic f_sing;
  lane_out_t [NUM_ELEMS-1:0] l_out;
  logic [LANE_LAT-1:0] dvld_r;
  logic [ELEM_W-1:0] ddet_r [LANE_LAT];
  logic dsing_r [LANE_LAT];
  mat_t inv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start & ~busy_r;
  assign mat    = {in_a22, in_a21, in_a20, in_a12, in_a11, in_a10, in_a02, in_a01, in_a00};

  miv_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_vld      (accept),
    .in_a        (mat),
    .out_vld     (f_vld),
    .out_lanes   (f_lanes),
    .out_det     (f_det),
    .out_singular(f_sing)
  );

  for (genvar k = 0; k < NUM_ELEMS; k++) begin : g_lane
    miv_lane u_lane (
      .clk (clk),
      .lin (f_lanes[k]),
      .lout(l_out[k])
    );
  end

  // Side information travels alongside the divider lanes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvld_r <= '0;
    end else begin
      dvld_r <= {dvld_r[LANE_LAT-2:0], f_vld};
    end
  end

  always_ff @(posedge clk) begin
    ddet_r[0]  <= f_det;
    dsing_r[0] <= f_sing;
    for (int s = 1; s < LANE_LAT; s++) begin
      ddet_r[s]  <= ddet_r[s-1];
      dsing_r[s] <= dsing_r[s-1];
    end
  end

  miv_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_vld      (dvld_r[LANE_LAT-1]),
    .in_lanes    (l_out),
    .in_det      (ddet_r[LANE_LAT-1]),
    .in_singular (dsing_r[LANE_LAT-1]),
    .out_vld     (out_valid),
    .out_inv     (inv),
    .out_det     (out_determinant),
    .out_singular(out_singular)
  );

  assign out_inv00 = inv[0];
  assign out_inv01 = inv[1];
  assign out_inv02 = inv[2];
  assign out_inv10 = inv[3];
  assign out_inv11 = inv[4];
  assign out_inv12 = inv[5];
  assign out_inv20 = inv[6];
  assign out_inv21 = inv[7];
  assign out_inv22 = inv[8];

endmodule

/* sv/miv_checker.sv */
// Port-level checks for the matrix inverse unit, bound to the top level.
module miv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [31:0] out_inv00,
  input logic [31:0] out_inv11,
  input logic [31:0] out_inv22,
  input logic [31:0] out_determinant,
  input logic        out_singular
);
  import miv_pkg::*;

  // Every accepted transaction produces a result at a fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("accepted transaction produced no result strobe");

  // A result strobe always traces back to an accepted transaction.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result strobe without an accepted transaction");

  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_singular |-> (out_inv00 == 32'd0 && out_inv11 == 32'd0 &&
                      out_inv22 == 32'd0 && out_determinant == 32'd0))
    else $error("singular result carries nonzero fields");

  a_sing_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_singular |-> out_valid)
    else $error("singular flag outside a result");

endmodule

bind matrix_inverse_3x3_unit miv_checker u_miv_checker (.*);
